// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

	localparam int DEPTH = 256;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int REQ_W = 3;
	localparam int ST_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_TAKE_FRONT = 3'd2,
		REQ_TAKE_BACK  = 3'd3,
		REQ_REVERSE    = 3'd4,
		REQ_CLEAR      = 3'd5
	} req_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic             mem_we;
		logic             mem_re;
		logic [IDX_W-1:0] addr;
		logic             take_ok;
		status_t          status;
		logic [CNT_W-1:0] count;
	} ctl_t;

endpackage

// ===== hw/rtl/double_ended_queue_unit.sv =====
// channel  dir  handshake          payload
// in       in   in_valid/in_stall   req_type[2:0], data_value[31:0]
// out      out  out_valid/out_stall out_value[31:0], status[1:0], count[8:0]
//
// One transfer per cycle while out_stall is low; a result passes from the registered read of the
// entry RAM in the read stage to the output register.
// Pointer and count registers update at the input transfer, so back-to-back
// requests see the state left by the previous one.
// Reset clears pointers, count and direction; RAM contents stay undefined.
// out_stall holds the output register and the read stage; in_stall rises once both are full.
module double_ended_queue_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [deq_pkg::REQ_W-1:0]   req_type,
	input  logic signed [deq_pkg::DATA_W-1:0] data_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [deq_pkg::DATA_W-1:0] out_value,
	output logic [deq_pkg::ST_W-1:0]    status,
	output logic [deq_pkg::CNT_W-1:0]   count
);
	import deq_pkg::*;

	ctl_t              ctl;
	logic              accept;
	logic              s1_adv;
	logic [DATA_W-1:0] rd_data;

	logic              valid_s1;
	logic              take_ok_s1;
	status_t           status_s1;
	logic [CNT_W-1:0]  count_s1;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	status_t           status_q;
	logic [CNT_W-1:0]  count_q;

	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req_type),
		.ctl    (ctl)
	);

	deq_mem u_mem (
		.clk     (clk),
		.wr_en   (ctl.mem_we),
		.rd_en   (ctl.mem_re),
		.addr    (ctl.addr),
		.wr_data (data_value),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			take_ok_s1 <= ctl.take_ok;
			status_s1  <= ctl.status;
			count_s1   <= ctl.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_value_q <= take_ok_s1 ? rd_data : '0;
			status_q    <= status_s1;
			count_q     <= count_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign status    = status_q;
	assign count     = count_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.count <= CNT_W'(DEPTH))
		else $error("count beyond depth");

	a_mem_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.mem_we && ctl.mem_re))
		else $error("RAM read and write in one cycle");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted transfer lost before read stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(rd_data) && $stable(count_s1)))
		else $error("stalled read stage changed");
`endif

endmodule

// ===== hw/rtl/deq_mem.sv =====
module deq_mem (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic                         rd_en,
	input  logic [deq_pkg::IDX_W-1:0]    addr,
	input  logic [deq_pkg::DATA_W-1:0]   wr_data,
	output logic [deq_pkg::DATA_W-1:0]   rd_data
);
	import deq_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
module deq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [deq_pkg::REQ_W-1:0]  req,
	output deq_pkg::ctl_t              ctl
);
	import deq_pkg::*;

	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic             rev_q;

	logic [IDX_W-1:0] front_d;
	logic [CNT_W-1:0] count_d;
	logic             rev_d;
	logic             at_low;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] below_low;
	logic [IDX_W-1:0] above_high;
	logic [IDX_W-1:0] top_slot;
	logic [IDX_W-1:0] front_inc;
	logic [CNT_W:0]   sum_hi;
	logic [CNT_W:0]   sum_top;

	localparam logic [CNT_W:0] DEPTH_X = (CNT_W+1)'(DEPTH);

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		sum_hi  = (CNT_W+1)'(front_q) + (CNT_W+1)'(count_q);
		sum_top = sum_hi - (CNT_W+1)'(1);
		above_high = (sum_hi >= DEPTH_X) ? IDX_W'(sum_hi - DEPTH_X) : IDX_W'(sum_hi);
		top_slot   = (sum_top >= DEPTH_X) ? IDX_W'(sum_top - DEPTH_X) : IDX_W'(sum_top);
		below_low  = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
		front_inc  = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + IDX_W'(1);
	end

	always_comb begin
		front_d     = front_q;
		count_d     = count_q;
		rev_d       = rev_q;
		at_low      = 1'b0;
		ctl.mem_we  = 1'b0;
		ctl.mem_re  = 1'b0;
		ctl.addr    = front_q;
		ctl.take_ok = 1'b0;
		ctl.status  = ST_OK;
		case (req)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				at_low = ((req == REQ_PUSH_FRONT) == !rev_q);
				if (full) begin
					ctl.status = ST_FULL;
				end else begin
					ctl.mem_we = accept;
					count_d    = count_q + CNT_W'(1);
					if (at_low) begin
						ctl.addr = below_low;
						front_d  = below_low;
					end else begin
						ctl.addr = above_high;
					end
				end
			end
			REQ_TAKE_FRONT, REQ_TAKE_BACK: begin
				at_low = ((req == REQ_TAKE_FRONT) == !rev_q);
				if (empty) begin
					ctl.status = ST_EMPTY;
				end else begin
					ctl.mem_re  = accept;
					ctl.take_ok = 1'b1;
					count_d     = count_q - CNT_W'(1);
					if (at_low) begin
						ctl.addr = front_q;
						front_d  = front_inc;
					end else begin
						ctl.addr = top_slot;
					end
				end
			end
			REQ_REVERSE: begin
				rev_d = !rev_q;
			end
			REQ_CLEAR: begin
				front_d = '0;
				count_d = '0;
				rev_d   = 1'b0;
			end
			default: begin
			end
		endcase
		ctl.count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (accept) begin
			front_q <= front_d;
			count_q <= count_d;
			rev_q   <= rev_d;
		end
	end

endmodule
